[src/text_console_writer_defines.svh]
// Assertion helpers for the checker of the text console writer.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// The consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

// The consequent must hold in the cycle that follows a reset cycle.
`define TCW_ASSERT_AFTER_RESET(name, clk, rst, cons) \
  name: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("%m: check failed");

`endif

[src/tcw_pkg.sv]
package tcw_pkg;

  localparam int DEF_ROWS = 25;
  localparam int DEF_COLS = 80;
  localparam int QUEUE_DEPTH = 2;
  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] ATTR_RESET = 8'h1F;

  typedef struct packed {
    logic       func;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } tcw_in_t;

  typedef struct packed {
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
  } tcw_out_t;

  typedef enum logic [1:0] {
    KIND_PUT,
    KIND_NEWLINE,
    KIND_READ,
    KIND_READ_NONE
  } tcw_kind_t;

  typedef struct packed {
    tcw_kind_t  kind;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } tcw_cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_READ_WAIT,
    ST_SCROLL,
    ST_SCROLL_END,
    ST_PUT
  } tcw_state_t;

endpackage

[src/tcw_front.sv]
module tcw_front #(
  parameter int NUM_ROWS = tcw_pkg::DEF_ROWS,
  parameter int NUM_COLS = tcw_pkg::DEF_COLS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  tcw_pkg::tcw_in_t cmd,
  input  logic             hold,
  output logic             q_valid,
  output tcw_pkg::tcw_cmd_t q_head,
  input  logic             q_pop
);

  localparam int PTR_W = (tcw_pkg::QUEUE_DEPTH > 1) ? $clog2(tcw_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(tcw_pkg::QUEUE_DEPTH + 1);

  tcw_pkg::tcw_cmd_t entries [tcw_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  tcw_pkg::tcw_cmd_t classified;
  logic              push;
  logic              full;
  logic              in_range;

  always_comb begin
    in_range = (7'(cmd.read_row) < 7'(NUM_ROWS)) && (8'(cmd.read_col) < 8'(NUM_COLS));
    classified.char_code = cmd.char_code;
    classified.read_row  = cmd.read_row;
    classified.read_col  = cmd.read_col;
    priority if (cmd.func) begin
      classified.kind = in_range ? tcw_pkg::KIND_READ : tcw_pkg::KIND_READ_NONE;
    end else if (cmd.char_code == tcw_pkg::NEWLINE_CODE) begin
      classified.kind = tcw_pkg::KIND_NEWLINE;
    end else begin
      classified.kind = tcw_pkg::KIND_PUT;
    end
  end

  assign full    = (count == CNT_W'(tcw_pkg::QUEUE_DEPTH));
  assign busy    = rst | hold | full;
  assign push    = start & ~busy;
  assign q_valid = (count != '0);
  assign q_head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop && q_valid) begin
        rd_ptr <= (rd_ptr == PTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(q_pop && q_valid);
    end
  end

endmodule

[src/tcw_back.sv]
module tcw_back #(
  parameter int NUM_ROWS = tcw_pkg::DEF_ROWS,
  parameter int NUM_COLS = tcw_pkg::DEF_COLS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  input  logic              q_valid,
  input  tcw_pkg::tcw_cmd_t q_head,
  output logic              q_pop,
  output logic              hold,
  output logic              done,
  output tcw_pkg::tcw_out_t result
);

  localparam int CELLS       = NUM_ROWS * NUM_COLS;
  localparam int ADDR_W      = $clog2(CELLS);
  localparam int COL_W       = $clog2(NUM_COLS + 1);
  localparam int ROW_W       = $clog2(NUM_ROWS + 1);
  localparam int SHIFT_LIMIT = (NUM_ROWS - 1) * NUM_COLS;

  tcw_pkg::tcw_state_t state;
  tcw_pkg::tcw_state_t state_next;
  tcw_pkg::tcw_cmd_t   cur;

  logic [15:0]       mem [CELLS];
  logic [15:0]       rdata;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [15:0]       wdata;
  logic              re;
  logic [ADDR_W-1:0] raddr;

  logic [7:0]        attr;
  logic [COL_W-1:0]  x;
  logic [COL_W-1:0]  x_next;
  logic [ROW_W-1:0]  y;
  logic [ROW_W-1:0]  y_next;
  logic [ADDR_W-1:0] sc;
  logic [ADDR_W-1:0] sc_next;
  logic              sc_last;
  logic              cp_pend;
  logic              cp_last;
  logic [ADDR_W-1:0] cp_addr;
  logic              cp_set;
  logic              emit;
  logic              rd_cell;

  logic              wrap;
  logic [ROW_W-1:0]  y_inc;
  logic [ROW_W-1:0]  y_put;
  logic              past_bottom_nl;
  logic              past_bottom_put;
  logic [ADDR_W-1:0] mul_row;
  logic [ADDR_W-1:0] mul_col;
  logic [ADDR_W-1:0] addr_calc;
  logic              sc_in_last_row;

  assign wrap            = (x >= COL_W'(NUM_COLS));
  assign y_inc           = y + 1'b1;
  assign y_put           = wrap ? y_inc : y;
  assign past_bottom_nl  = (y_inc >= ROW_W'(NUM_ROWS));
  assign past_bottom_put = (y_put >= ROW_W'(NUM_ROWS));
  assign sc_last         = (sc == ADDR_W'(CELLS - 1));
  assign sc_in_last_row  = (sc >= ADDR_W'(SHIFT_LIMIT));
  assign addr_calc       = mul_row * ADDR_W'(NUM_COLS) + mul_col;
  assign hold            = (state == tcw_pkg::ST_CLEAR);

  always_comb begin
    state_next = state;
    unique case (state)
      tcw_pkg::ST_CLEAR: begin
        if (sc_last) begin
          state_next = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_IDLE: begin
        if (q_valid) begin
          state_next = tcw_pkg::ST_EXEC;
        end
      end
      tcw_pkg::ST_EXEC: begin
        unique case (cur.kind)
          tcw_pkg::KIND_READ:      state_next = tcw_pkg::ST_READ_WAIT;
          tcw_pkg::KIND_READ_NONE: state_next = tcw_pkg::ST_IDLE;
          tcw_pkg::KIND_NEWLINE: begin
            state_next = past_bottom_nl ? tcw_pkg::ST_SCROLL : tcw_pkg::ST_IDLE;
          end
          tcw_pkg::KIND_PUT: begin
            state_next = past_bottom_put ? tcw_pkg::ST_SCROLL : tcw_pkg::ST_PUT;
          end
        endcase
      end
      tcw_pkg::ST_READ_WAIT: state_next = tcw_pkg::ST_IDLE;
      tcw_pkg::ST_SCROLL: begin
        if (sc_last) begin
          state_next = tcw_pkg::ST_SCROLL_END;
        end
      end
      tcw_pkg::ST_SCROLL_END: begin
        state_next = (cur.kind == tcw_pkg::KIND_NEWLINE) ? tcw_pkg::ST_IDLE : tcw_pkg::ST_PUT;
      end
      tcw_pkg::ST_PUT: state_next = tcw_pkg::ST_IDLE;
      default: state_next = tcw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    x_next  = x;
    y_next  = y;
    sc_next = sc;
    q_pop   = 1'b0;
    emit    = 1'b0;
    rd_cell = 1'b0;
    cp_set  = 1'b0;
    re      = 1'b0;
    mul_row = ADDR_W'(y);
    mul_col = ADDR_W'(x);
    raddr   = addr_calc;
    we      = cp_pend;
    waddr   = cp_addr;
    wdata   = cp_last ? {rdata[15:8], 8'h00} : rdata;
    unique case (state)
      tcw_pkg::ST_CLEAR: begin
        we      = 1'b1;
        waddr   = sc;
        wdata   = '0;
        sc_next = sc_last ? '0 : sc + 1'b1;
      end
      tcw_pkg::ST_IDLE: begin
        q_pop = q_valid;
      end
      tcw_pkg::ST_EXEC: begin
        unique case (cur.kind)
          tcw_pkg::KIND_READ: begin
            mul_row = ADDR_W'(cur.read_row);
            mul_col = ADDR_W'(cur.read_col);
            re      = 1'b1;
          end
          tcw_pkg::KIND_READ_NONE: begin
            emit = 1'b1;
          end
          tcw_pkg::KIND_NEWLINE: begin
            x_next = '0;
            y_next = y_inc;
            emit   = ~past_bottom_nl;
          end
          tcw_pkg::KIND_PUT: begin
            if (wrap) begin
              x_next = '0;
              y_next = y_inc;
            end
          end
        endcase
      end
      tcw_pkg::ST_READ_WAIT: begin
        emit    = 1'b1;
        rd_cell = 1'b1;
      end
      tcw_pkg::ST_SCROLL: begin
        re      = 1'b1;
        raddr   = sc_in_last_row ? sc : sc + ADDR_W'(NUM_COLS);
        cp_set  = 1'b1;
        sc_next = sc_last ? '0 : sc + 1'b1;
      end
      tcw_pkg::ST_SCROLL_END: begin
        y_next = y - 1'b1;
        emit   = (cur.kind == tcw_pkg::KIND_NEWLINE);
      end
      tcw_pkg::ST_PUT: begin
        we     = 1'b1;
        waddr  = addr_calc;
        wdata  = {attr, cur.char_code};
        x_next = x + 1'b1;
        emit   = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= tcw_pkg::ST_CLEAR;
      attr    <= tcw_pkg::ATTR_RESET;
      x       <= '0;
      y       <= '0;
      sc      <= '0;
      cp_pend <= 1'b0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      x       <= x_next;
      y       <= y_next;
      sc      <= sc_next;
      cp_pend <= cp_set;
      done    <= emit;
      if (cfg_we) begin
        attr <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    cp_addr <= sc;
    cp_last <= sc_in_last_row;
    if (q_pop) begin
      cur <= q_head;
    end
    if (emit) begin
      result.cursor_col <= 7'(x_next);
      result.cursor_row <= 5'(y_next);
      result.cell_char  <= rd_cell ? rdata[7:0] : 8'h00;
      result.cell_attr  <= rd_cell ? rdata[15:8] : 8'h00;
    end
  end

endmodule

[src/text_console_writer.sv]
// Text console of NUM_ROWS by NUM_COLS character cells. Start an item with
// start while busy is low; its single result appears on result for exactly one
// cycle with done high and must be taken then, since the block never waits for
// the receiver. A two-entry command queue sits in front of the executor, so
// up to two items are taken while earlier ones are still being carried out.
// With the executor idle, a put passes through the states ST_IDLE, ST_EXEC and
// ST_PUT, and an in-range read through ST_IDLE, ST_EXEC and ST_READ_WAIT, before
// done is registered; a newline or an out-of-range read raises done from ST_EXEC.
// The executor takes its next item in the cycle of done and carries out one item
// at a time, so a steady stream of puts steps through ST_IDLE, ST_EXEC and ST_PUT
// for each item. A scroll sweeps the whole screen memory once, one cell per cycle
// through its one read port and one write port, before the item goes on. After
// reset the screen memory is cleared one cell per cycle, and busy stays high
// until the clear is done. The attribute register is written with cfg_we and
// cfg_wdata and is meant to change only while no item is in flight.
module text_console_writer #(
  parameter int NUM_ROWS = tcw_pkg::DEF_ROWS,
  parameter int NUM_COLS = tcw_pkg::DEF_COLS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  tcw_pkg::tcw_in_t  cmd,
  output logic              done,
  output tcw_pkg::tcw_out_t result,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata
);

  logic              hold;
  logic              q_valid;
  logic              q_pop;
  tcw_pkg::tcw_cmd_t q_head;

  tcw_front #(
    .NUM_ROWS(NUM_ROWS),
    .NUM_COLS(NUM_COLS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .hold   (hold),
    .q_valid(q_valid),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  tcw_back #(
    .NUM_ROWS(NUM_ROWS),
    .NUM_COLS(NUM_COLS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .hold     (hold),
    .done     (done),
    .result   (result)
  );

endmodule

[src/tcw_checker.sv]
`include "text_console_writer_defines.svh"

module tcw_checker #(
  parameter int NUM_ROWS = tcw_pkg::DEF_ROWS,
  parameter int NUM_COLS = tcw_pkg::DEF_COLS
) (
  input logic              clk,
  input logic              rst,
  input logic              busy,
  input logic              done,
  input tcw_pkg::tcw_out_t result
);

  // Every result beat is followed by a quiet cycle.
  `TCW_ASSERT_NEXT(a_done_gap, clk, rst, done, !done)
  `TCW_ASSERT_NOW(a_row_range, clk, rst, done, 8'(result.cursor_row) < 8'(NUM_ROWS))
  `TCW_ASSERT_NOW(a_col_range, clk, rst, done, 8'(result.cursor_col) <= 8'(NUM_COLS))
  // The screen is being cleared right after reset.
  `TCW_ASSERT_AFTER_RESET(a_clear_busy, clk, rst, busy)

endmodule

bind text_console_writer tcw_checker #(
  .NUM_ROWS(NUM_ROWS),
  .NUM_COLS(NUM_COLS)
) u_tcw_checker (
  .clk   (clk),
  .rst   (rst),
  .busy  (busy),
  .done  (done),
  .result(result)
);
